// File: rtl/core/lps_pkg.sv
// Package: types, constants and register codes for the LED pixel SPI bit encoder.
`timescale 1ns / 1ps

package lps_pkg;

  localparam int MAX_PIXELS_DEF   = 1024;
  localparam int MAX_PREAMBLE_DEF = 40;

  localparam int BITS_PER_PIXEL = 24;
  localparam int BIT_IDX_W      = 5;
  localparam int CFG_PPF_W      = 11;
  localparam int CFG_PLEN_W     = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 11;

  localparam logic [CFG_PPF_W-1:0]  PPF_RESET      = 11'd128;
  localparam logic [CFG_PLEN_W-1:0] PLEN_RESET     = 6'd40;
  localparam logic [7:0]            ZERO_PAT_RESET = 8'b11100000;
  localparam logic [7:0]            ONE_PAT_RESET  = 8'b11111000;
  localparam logic [7:0]            PRE_BYTE_RESET = 8'b00000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXELS_PER_FRAME = 3'd0,
    REG_PREAMBLE_LEN     = 3'd1,
    REG_ZERO_PATTERN     = 3'd2,
    REG_ONE_PATTERN      = 3'd3,
    REG_PREAMBLE_BYTE    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_START,
    ST_PRE,
    ST_DATA
  } back_state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       last_of_item;
    logic       end_of_frame;
  } result_t;

  typedef struct packed {
    logic [BITS_PER_PIXEL-1:0] word;
    logic                      first;
    logic                      frame_end;
  } entry_t;

  typedef struct packed {
    logic [CFG_PPF_W-1:0]  pixels_per_frame;
    logic [CFG_PLEN_W-1:0] preamble_len;
    logic [7:0]            zero_pattern;
    logic [7:0]            one_pattern;
    logic [7:0]            preamble_byte;
  } cfg_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

endpackage

// File: rtl/core/lps_front.sv
// Front end: accept pixel requests, track frame position, classify into queue entries.
`timescale 1ns / 1ps

module lps_front #(
  parameter int MAX_PIXELS = lps_pkg::MAX_PIXELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lps_pkg::pixel_t                     in_data,
  input  logic [lps_pkg::CFG_PPF_W-1:0]       pixels_per_frame,
  input  logic                                q_ready,
  output lps_pkg::q_wr_t                      q_wr
);

  localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CMP_W = (IDX_W + 1 > lps_pkg::CFG_PPF_W) ? IDX_W + 1 : lps_pkg::CFG_PPF_W;

  logic [IDX_W-1:0] pixel_index_r, pixel_index_nxt;
  logic [CMP_W-1:0] ppf_ext, nframe, idx_inc;
  logic             frame_end;
  logic             accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  always_comb begin
    ppf_ext = CMP_W'(pixels_per_frame);
    nframe  = ppf_ext;
    if (ppf_ext == '0) begin
      nframe = CMP_W'(1);
    end
    if (ppf_ext > CMP_W'(MAX_PIXELS)) begin
      nframe = CMP_W'(MAX_PIXELS);
    end
    idx_inc   = CMP_W'(pixel_index_r) + CMP_W'(1);
    frame_end = (idx_inc >= nframe);
    pixel_index_nxt = pixel_index_r;
    if (accept) begin
      pixel_index_nxt = frame_end ? '0 : idx_inc[IDX_W-1:0];
    end
  end

  always_comb begin
    q_wr.push            = accept;
    q_wr.entry.word      = {in_data.green, in_data.red, in_data.blue};
    q_wr.entry.first     = (pixel_index_r == '0);
    q_wr.entry.frame_end = frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_index_r <= '0;
    end else begin
      pixel_index_r <= pixel_index_nxt;
    end
  end

endmodule

// File: rtl/core/lps_queue.sv
// Two-entry queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module lps_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  lps_pkg::q_wr_t  q_wr,
  output logic            q_ready,
  output logic            q_valid,
  output lps_pkg::entry_t q_head,
  input  logic            q_pop
);

  lps_pkg::entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign q_ready = (count_r != 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_push = q_wr.push && q_ready;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/core/lps_back.sv
// Back end: sequence preamble and data bytes for the queue head into the output register.
`timescale 1ns / 1ps

module lps_back #(
  parameter int MAX_PREAMBLE = lps_pkg::MAX_PREAMBLE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lps_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  lps_pkg::entry_t  q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output lps_pkg::result_t out_data
);

  localparam int PW = lps_pkg::CFG_PLEN_W;

  lps_pkg::back_state_t state_r, state_nxt;
  logic [PW-1:0]        cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  lps_pkg::result_t     out_data_r, out_data_nxt;
  logic [PW-1:0]        plen, cnt_inc;
  logic                 adv;
  logic [lps_pkg::BIT_IDX_W-1:0] bit_sel;
  logic                 data_bit;
  lps_pkg::result_t     pre_res, data_res;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign adv       = !out_valid_r || out_ready;

  always_comb begin
    plen = cfg.preamble_len;
    if (32'(cfg.preamble_len) > MAX_PREAMBLE) begin
      plen = PW'(MAX_PREAMBLE);
    end
    cnt_inc  = cnt_r + PW'(1);
    bit_sel  = lps_pkg::BIT_IDX_W'(lps_pkg::BITS_PER_PIXEL - 1) - cnt_r[lps_pkg::BIT_IDX_W-1:0];
    data_bit = q_head.word[bit_sel];
    pre_res.spi_byte      = cfg.preamble_byte;
    pre_res.last_of_item  = 1'b0;
    pre_res.end_of_frame  = 1'b0;
    data_res.spi_byte     = data_bit ? cfg.one_pattern : cfg.zero_pattern;
    data_res.last_of_item = (cnt_r == PW'(lps_pkg::BITS_PER_PIXEL - 1));
    data_res.end_of_frame = data_res.last_of_item && q_head.frame_end;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    if (adv) begin
      out_valid_nxt = 1'b0;
      unique case (state_r)
        lps_pkg::ST_START: begin
          if (q_valid) begin
            out_valid_nxt = 1'b1;
            if (q_head.first && plen != '0) begin
              out_data_nxt = pre_res;
              if (plen == PW'(1)) begin
                state_nxt = lps_pkg::ST_DATA;
                cnt_nxt   = '0;
              end else begin
                state_nxt = lps_pkg::ST_PRE;
                cnt_nxt   = PW'(1);
              end
            end else begin
              out_data_nxt = data_res;
              state_nxt    = lps_pkg::ST_DATA;
              cnt_nxt      = PW'(1);
            end
          end
        end
        lps_pkg::ST_PRE: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pre_res;
          if (cnt_inc == plen) begin
            state_nxt = lps_pkg::ST_DATA;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        lps_pkg::ST_DATA: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_res;
          if (data_res.last_of_item) begin
            q_pop     = 1'b1;
            state_nxt = lps_pkg::ST_START;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          state_nxt = lps_pkg::ST_START;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lps_pkg::ST_START;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// File: rtl/core/led_pixel_spi_bit_encoder_top.sv
// Top level: LED pixel SPI bit encoder with configuration registers.
// A pixel's first byte reaches out_ through the queue and then the output register.
// Throughput, set by the back-end sequencer: 24 bytes per pixel at one byte per cycle
// if out_ready is high and a pixel waits, plus the preamble on a frame's first pixel.
// Reset: configuration returns to defaults, the pixel index clears and the queue empties.
`timescale 1ns / 1ps

module led_pixel_spi_bit_encoder_top #(
  parameter int MAX_PIXELS   = lps_pkg::MAX_PIXELS_DEF,
  parameter int MAX_PREAMBLE = lps_pkg::MAX_PREAMBLE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lps_pkg::pixel_t                  in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lps_pkg::result_t                 out_data,
  input  logic                             cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  lps_pkg::cfg_t   cfg_r, cfg_nxt;
  lps_pkg::q_wr_t  q_wr;
  logic            q_ready, q_valid, q_pop;
  lps_pkg::entry_t q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lps_pkg::REG_PIXELS_PER_FRAME: cfg_nxt.pixels_per_frame = cfg_data;
        lps_pkg::REG_PREAMBLE_LEN:     cfg_nxt.preamble_len = cfg_data[lps_pkg::CFG_PLEN_W-1:0];
        lps_pkg::REG_ZERO_PATTERN:     cfg_nxt.zero_pattern = cfg_data[7:0];
        lps_pkg::REG_ONE_PATTERN:      cfg_nxt.one_pattern = cfg_data[7:0];
        lps_pkg::REG_PREAMBLE_BYTE:    cfg_nxt.preamble_byte = cfg_data[7:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixels_per_frame <= lps_pkg::PPF_RESET;
      cfg_r.preamble_len     <= lps_pkg::PLEN_RESET;
      cfg_r.zero_pattern     <= lps_pkg::ZERO_PAT_RESET;
      cfg_r.one_pattern      <= lps_pkg::ONE_PAT_RESET;
      cfg_r.preamble_byte    <= lps_pkg::PRE_BYTE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lps_front #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .pixels_per_frame (cfg_r.pixels_per_frame),
    .q_ready          (q_ready),
    .q_wr             (q_wr)
  );

  lps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  lps_back #(
    .MAX_PREAMBLE(MAX_PREAMBLE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_frame |-> out_data.last_of_item)
    else $error("end_of_frame without last_of_item");

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  a_pop_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid && out_data.last_of_item)
    else $error("queue pop without final byte of pixel");

endmodule
